@@ hw/rtl/chs_pkg.sv @@
// shared types, codes and defaults for the chained hash set
package chs_pkg;

  localparam int unsigned BUCKETS_DEF    = 7;
  localparam int unsigned POOL_NODES_DEF = 256;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned VALUE_W        = 31;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_FIRST,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    mod_step;
    logic    head_rd;
    logic    pop_rd;
    logic    alloc;
    logic    head_wr_new;
    logic    head_wr_link;
    logic    node_rd_head;
    logic    node_rd_next;
    logic    link_wr_tail;
    logic    link_wr_prev;
    logic    push;
    logic    res_ld;
    status_e res;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic is_ins;
    logic is_srch;
    logic is_del;
    logic pool_empty;
    logic head_nil;
    logic link_nil;
    logic val_eq;
    logic prev_nil;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/chs_if.sv @@
// request and response channel interfaces
interface chs_req_if;
  logic                         valid;
  logic                         ready;
  logic [chs_pkg::OP_W-1:0]     req_type;
  logic [chs_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface chs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [chs_pkg::STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

@@ hw/rtl/chs_ctrl.sv @@
// controller state machine: sequences hashing, chain walks and table updates
module chs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  chs_pkg::stat_t stat_i,
  output chs_pkg::cmd_t  cmd_o
);

  chs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chs_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.res   = chs_pkg::STAT_OK;
    case (state_q)
      chs_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = chs_pkg::S_IDLE;
        end
      end
      chs_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = chs_pkg::S_MOD;
        end
      end
      chs_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = chs_pkg::S_HEAD;
        end
      end
      chs_pkg::S_HEAD: begin
        if (stat_i.is_ins) begin
          if (stat_i.pool_empty) begin
            cmd_o.res_ld = 1'b1;
            cmd_o.res    = chs_pkg::STAT_FULL;
            state_d      = chs_pkg::S_DONE;
          end else begin
            cmd_o.head_rd = 1'b1;
            cmd_o.pop_rd  = 1'b1;
            state_d       = chs_pkg::S_FIRST;
          end
        end else if (stat_i.is_srch || stat_i.is_del) begin
          cmd_o.head_rd = 1'b1;
          state_d       = chs_pkg::S_FIRST;
        end else begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = chs_pkg::STAT_ABSENT;
          state_d      = chs_pkg::S_DONE;
        end
      end
      chs_pkg::S_FIRST: begin
        if (stat_i.is_ins) begin
          cmd_o.alloc = 1'b1;
          if (stat_i.head_nil) begin
            cmd_o.head_wr_new = 1'b1;
            cmd_o.res_ld      = 1'b1;
            cmd_o.res         = chs_pkg::STAT_OK;
            state_d           = chs_pkg::S_DONE;
          end else begin
            cmd_o.node_rd_head = 1'b1;
            state_d            = chs_pkg::S_WALK;
          end
        end else if (stat_i.head_nil) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = chs_pkg::STAT_ABSENT;
          state_d      = chs_pkg::S_DONE;
        end else begin
          cmd_o.node_rd_head = 1'b1;
          state_d            = chs_pkg::S_WALK;
        end
      end
      chs_pkg::S_WALK: begin
        if (stat_i.is_ins) begin
          if (stat_i.link_nil) begin
            cmd_o.link_wr_tail = 1'b1;
            cmd_o.res_ld       = 1'b1;
            cmd_o.res          = chs_pkg::STAT_OK;
            state_d            = chs_pkg::S_DONE;
          end else begin
            cmd_o.node_rd_next = 1'b1;
          end
        end else if (stat_i.val_eq) begin
          if (stat_i.is_del) begin
            cmd_o.head_wr_link = stat_i.prev_nil;
            cmd_o.link_wr_prev = !stat_i.prev_nil;
            cmd_o.push         = 1'b1;
          end
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = chs_pkg::STAT_OK;
          state_d      = chs_pkg::S_DONE;
        end else if (stat_i.link_nil) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = chs_pkg::STAT_ABSENT;
          state_d      = chs_pkg::S_DONE;
        end else begin
          cmd_o.node_rd_next = 1'b1;
        end
      end
      chs_pkg::S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = chs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/chs_dp.sv @@
// datapath: bucket hash, bucket heads, node pool, free stack and result register
module chs_dp #(
  parameter int unsigned BUCKETS    = chs_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [chs_pkg::OP_W-1:0]     req_type_i,
  input  logic [chs_pkg::VALUE_W-1:0]  item_value_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [chs_pkg::STATUS_W-1:0] status_o,
  input  chs_pkg::cmd_t                cmd_i,
  output chs_pkg::stat_t               stat_o
);

  localparam int unsigned NW = $clog2(POOL_NODES + 1);
  localparam int unsigned SW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned XW = BW + 8;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  logic [chs_pkg::OP_W-1:0]    op_q;
  logic [chs_pkg::VALUE_W-1:0] value_q;
  logic [BW-1:0]               rem_q, rem_d;
  logic [1:0]                  mod_cnt_q;
  logic [BW-1:0]               clr_cnt_q;
  logic [NW-1:0]               cur_q, prev_q;
  logic [SW-1:0]               new_q, pop_addr_q;
  logic [NW-1:0]               free_cnt_q, lwm_q;
  chs_pkg::status_e            res_q;
  logic                        out_valid_q;
  chs_pkg::status_e            out_status_q;

  logic [NW-1:0]               head_mem [BUCKETS];
  logic [chs_pkg::VALUE_W-1:0] val_mem  [POOL_NODES];
  logic [NW-1:0]               link_mem [POOL_NODES];
  logic [SW-1:0]               slot_mem [POOL_NODES];

  logic [NW-1:0]               head_rd_q;
  logic [chs_pkg::VALUE_W-1:0] val_rd_q;
  logic [NW-1:0]               link_rd_q;
  logic [SW-1:0]               slot_rd_q;

  logic [31:0]   val32;
  logic [7:0]    chunk;
  logic [XW-1:0] mod_x;
  logic [SW-1:0] alloc_node;
  logic [SW-1:0] node_rd_addr;
  logic          node_rd;
  logic          link_we;
  logic [SW-1:0] link_wa;
  logic [NW-1:0] link_wd;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [NW-1:0] head_wd;

  // bucket = value mod BUCKETS, one byte per step, msb first
  always_comb begin
    val32 = {1'b0, value_q};
    chunk = val32[{~mod_cnt_q, 3'b000} +: 8];
    mod_x = {rem_q, chunk};
    for (int i = 7; i >= 0; i--) begin
      if (mod_x >= (XW'(BUCKETS) << i)) begin
        mod_x = mod_x - (XW'(BUCKETS) << i);
      end
    end
    rem_d = mod_x[BW-1:0];
  end

  // free stack entries at or above the low-water mark hold pushed nodes
  assign alloc_node = (lwm_q <= NW'(pop_addr_q)) ? slot_rd_q : pop_addr_q;

  assign node_rd      = cmd_i.node_rd_head | cmd_i.node_rd_next;
  assign node_rd_addr = cmd_i.node_rd_head ? head_rd_q[SW-1:0] : link_rd_q[SW-1:0];

  always_comb begin
    link_we = 1'b1;
    link_wa = alloc_node;
    link_wd = NIL;
    if (cmd_i.link_wr_tail) begin
      link_wa = cur_q[SW-1:0];
      link_wd = NW'(new_q);
    end else if (cmd_i.link_wr_prev) begin
      link_wa = prev_q[SW-1:0];
      link_wd = link_rd_q;
    end else if (!cmd_i.alloc) begin
      link_we = 1'b0;
    end
  end

  always_comb begin
    head_we = cmd_i.clr_step | cmd_i.head_wr_new | cmd_i.head_wr_link;
    head_wa = cmd_i.clr_step ? clr_cnt_q : rem_q;
    head_wd = NIL;
    if (cmd_i.head_wr_new) begin
      head_wd = NW'(alloc_node);
    end else if (cmd_i.head_wr_link) begin
      head_wd = link_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q   <= '0;
      clr_cnt_q   <= '0;
      free_cnt_q  <= NW'(POOL_NODES);
      lwm_q       <= NW'(POOL_NODES);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + 2'd1;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + BW'(1);
      end
      if (cmd_i.alloc) begin
        free_cnt_q <= free_cnt_q - NW'(1);
        if (NW'(pop_addr_q) < lwm_q) begin
          lwm_q <= NW'(pop_addr_q);
        end
      end else if (cmd_i.push && (free_cnt_q < NW'(POOL_NODES))) begin
        free_cnt_q <= free_cnt_q + NW'(1);
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= req_type_i;
      value_q <= item_value_i;
      rem_q   <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
    end
    if (cmd_i.pop_rd) begin
      pop_addr_q <= SW'(free_cnt_q - NW'(1));
    end
    if (cmd_i.alloc) begin
      new_q <= alloc_node;
    end
    if (cmd_i.node_rd_head) begin
      cur_q  <= head_rd_q;
      prev_q <= NIL;
    end else if (cmd_i.node_rd_next) begin
      cur_q  <= link_rd_q;
      prev_q <= cur_q;
    end
    if (cmd_i.res_ld) begin
      res_q <= cmd_i.res;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (cmd_i.head_rd) begin
      head_rd_q <= head_mem[rem_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      val_mem[alloc_node] <= value_q;
    end
    if (node_rd) begin
      val_rd_q <= val_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (node_rd) begin
      link_rd_q <= link_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (free_cnt_q < NW'(POOL_NODES))) begin
      slot_mem[free_cnt_q[SW-1:0]] <= cur_q[SW-1:0];
    end
    if (cmd_i.pop_rd) begin
      slot_rd_q <= slot_mem[SW'(free_cnt_q - NW'(1))];
    end
  end

  assign stat_o.clr_last   = (clr_cnt_q == BW'(BUCKETS - 1));
  assign stat_o.mod_last   = (mod_cnt_q == 2'd3);
  assign stat_o.is_ins     = (op_q == chs_pkg::OP_INSERT);
  assign stat_o.is_srch    = (op_q == chs_pkg::OP_SEARCH);
  assign stat_o.is_del     = (op_q == chs_pkg::OP_DELETE);
  assign stat_o.pool_empty = (free_cnt_q == '0);
  assign stat_o.head_nil   = (head_rd_q >= NIL);
  assign stat_o.link_nil   = (link_rd_q >= NIL);
  assign stat_o.val_eq     = (val_rd_q == value_q);
  assign stat_o.prev_nil   = (prev_q >= NIL);
  assign stat_o.out_busy   = out_valid_q & ~rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign status_o    = out_status_q;

endmodule

@@ hw/rtl/chained_hash_set.sv @@
// top level of the chained hash set
//
// req_i carries one request: req_type (insert, search, delete) and item_value.
// rsp_o returns one status per request, in request order: done or found,
// not present, or node pool full for an insert with no free node.
// The bucket is item_value mod BUCKETS, found by a byte-serial remainder unit.
// Chains live in a node pool with one read port, so a walk advances one
// node per cycle.
// After acceptance a request runs the remainder steps, reads its bucket head
// and walks its chain before it reaches the result register (search and
// delete stop at the first match, insert walks to the tail); an unused
// operation or a full pool skips the head read. One request is in work at a
// time, so a new one is taken only after the last has reached the output register.
// The result sits in an output register: a new request is accepted while it
// waits, and if rsp_o stalls the next request holds in its last step until
// the register frees.
// After reset a clearing pass empties the bucket heads, one per cycle;
// req_i.ready stays low during that pass.
module chained_hash_set #(
  parameter int unsigned BUCKETS    = chs_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chs_req_if.sink   req_i,
  chs_rsp_if.source rsp_o
);

  chs_pkg::cmd_t  cmd;
  chs_pkg::stat_t stat;

  chs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  chs_dp #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_i.req_type),
    .item_value_i (req_i.item_value),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .status_o     (rsp_o.status),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

@@ hw/rtl/chs_checker.sv @@
// port-level checker for the chained hash set, bound to the top level
module chs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [chs_pkg::STATUS_W-1:0] rsp_status_i
);

  logic [1:0] pend_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i & req_ready_i;
  assign rsp_acc = rsp_valid_i & rsp_ready_i;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("response dropped or changed while stalled");

  a_no_extra_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> pend_q != 2'd0)
    else $error("response without an open request");

  a_two_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !req_ready_i)
    else $error("request taken with work and result register both full");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i == chs_pkg::STAT_OK || rsp_status_i == chs_pkg::STAT_ABSENT
                    || rsp_status_i == chs_pkg::STAT_FULL)
    else $error("unknown status code");

endmodule

bind chained_hash_set chs_checker u_chs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status)
);

@@ test/tb_top.sv @@
// self-checking testbench for the chained hash set: directed table, then random traffic
module tb_top;

  localparam int unsigned BUCKETS    = chs_pkg::BUCKETS_DEF;
  localparam int unsigned POOL       = chs_pkg::POOL_NODES_DEF;
  localparam logic [8:0]  NIL        = 9'(chs_pkg::POOL_NODES_DEF);
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;
  localparam int unsigned SET_SIZE   = 24;
  localparam int unsigned DIR_ROWS   = 27;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct packed {
    logic [1:0]       op;
    logic [30:0]      value;
    logic             fixed;
    chs_pkg::status_e status;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  chs_req_if req_bus ();
  chs_rsp_if rsp_bus ();

  chained_hash_set u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the set
  logic [8:0]  chain_head [BUCKETS];
  logic [30:0] node_val   [POOL];
  logic [8:0]  node_next  [POOL];
  logic [7:0]  free_stack [POOL];
  logic [8:0]  free_nodes;

  chs_pkg::status_e pending_status_q [$];
  logic [30:0]      value_set [SET_SIZE];
  bit               steady = 1'b0;

  int unsigned status_errors = 0;
  int unsigned checked_cnt   = 0;
  int unsigned op_cnt [4]    = '{0, 0, 0, 0};
  int unsigned full_cnt      = 0;
  int unsigned absent_cnt    = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{chs_pkg::OP_SEARCH, 31'd0,         1'b1, chs_pkg::STAT_ABSENT},
    '{chs_pkg::OP_DELETE, VALUE_MAX,     1'b1, chs_pkg::STAT_ABSENT},
    '{OP_UNUSED,          31'd5,         1'b1, chs_pkg::STAT_ABSENT},
    '{chs_pkg::OP_INSERT, 31'd0,         1'b1, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, VALUE_MAX,     1'b1, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'd7,         1'b1, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'd7,         1'b1, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd14,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_DELETE, 31'd0,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd0,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_DELETE, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_DELETE, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_DELETE, 31'd7,         1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'h2AAA_AAAA, 1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'h5555_5555, 1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'h2AAA_AAAA, 1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'h5555_5555, 1'b0, chs_pkg::STAT_OK},
    '{OP_UNUSED,          VALUE_MAX,     1'b1, chs_pkg::STAT_ABSENT},
    '{chs_pkg::OP_INSERT, 31'd21,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'd28,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_INSERT, 31'd35,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_DELETE, 31'd28,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd35,        1'b0, chs_pkg::STAT_OK},
    '{chs_pkg::OP_SEARCH, 31'd28,        1'b0, chs_pkg::STAT_OK}
  };

  function automatic chs_pkg::status_e hash_set_apply(input logic [1:0] op,
                                                      input logic [30:0] value);
    logic [8:0]       cur;
    logic [8:0]       prev;
    logic [8:0]       node;
    int unsigned      bkt;
    chs_pkg::status_e st;
    bkt = value % BUCKETS;
    st  = chs_pkg::STAT_ABSENT;
    case (op)
      chs_pkg::OP_INSERT: begin
        if (free_nodes == 0) begin
          st = chs_pkg::STAT_FULL;
        end else begin
          free_nodes      = free_nodes - 9'd1;
          node            = {1'b0, free_stack[free_nodes]};
          node_val[node]  = value;
          node_next[node] = NIL;
          if (chain_head[bkt] >= NIL) begin
            chain_head[bkt] = node;
          end else begin
            cur = chain_head[bkt];
            for (int s = 0; s < POOL && node_next[cur] < NIL; s++) cur = node_next[cur];
            node_next[cur] = node;
          end
          st = chs_pkg::STAT_OK;
        end
      end
      chs_pkg::OP_SEARCH: begin
        cur = chain_head[bkt];
        for (int s = 0; s < POOL && cur < NIL && st != chs_pkg::STAT_OK; s++) begin
          if (node_val[cur] == value) st = chs_pkg::STAT_OK;
          else cur = node_next[cur];
        end
      end
      chs_pkg::OP_DELETE: begin
        cur  = chain_head[bkt];
        prev = NIL;
        for (int s = 0; s < POOL && cur < NIL && st != chs_pkg::STAT_OK; s++) begin
          if (node_val[cur] == value) begin
            if (prev < NIL) node_next[prev] = node_next[cur];
            else chain_head[bkt] = node_next[cur];
            if (free_nodes < NIL) begin
              free_stack[free_nodes] = cur[7:0];
              free_nodes             = free_nodes + 9'd1;
            end
            st = chs_pkg::STAT_OK;
          end else begin
            prev = cur;
            cur  = node_next[cur];
          end
        end
      end
      default: st = chs_pkg::STAT_ABSENT;
    endcase
    return st;
  endfunction

  function automatic logic [1:0] pick_op(input int unsigned ins_pct, input int unsigned srch_pct,
                                         input int unsigned del_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return chs_pkg::OP_INSERT;
    if (r < ins_pct + srch_pct) return chs_pkg::OP_SEARCH;
    if (r < ins_pct + srch_pct + del_pct) return chs_pkg::OP_DELETE;
    return OP_UNUSED;
  endfunction

  function automatic logic [30:0] pick_value();
    if ($urandom_range(0, 9) < 8) return value_set[$urandom_range(0, SET_SIZE - 1)];
    return 31'($urandom() & VALUE_MAX);
  endfunction

  task automatic refill_value_set();
    value_set[0] = 31'd0;
    value_set[1] = VALUE_MAX;
    value_set[2] = 31'd7;
    value_set[3] = 31'd14;
    for (int i = 4; i < SET_SIZE; i++) value_set[i] = 31'($urandom() & VALUE_MAX);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [30:0] value,
                              input logic fixed, input chs_pkg::status_e fixed_status);
    int unsigned      gap;
    chs_pkg::status_e predicted;
    gap = 0;
    if (!steady && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= op;
    req_bus.item_value <= value;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = hash_set_apply(op, value);
    pending_status_q.push_back(fixed ? fixed_status : predicted);
    op_cnt[op]++;
    if (predicted == chs_pkg::STAT_FULL) full_cnt++;
    if (predicted == chs_pkg::STAT_ABSENT) absent_cnt++;
  endtask

  task automatic wait_all_answered();
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  // response side back-pressure
  initial begin : rsp_ready_drive
    rsp_bus.ready = 1'b1;
    @(posedge rst_ni);
    forever begin
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!steady && $urandom_range(0, 2) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    chs_pkg::status_e want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_status_q.size() == 0) begin
        status_errors++;
        if (status_errors <= MAX_REPORT)
          $display("unexpected response: status %0d with nothing pending", rsp_bus.status);
      end else begin
        want = pending_status_q.pop_front();
        checked_cnt++;
        if (rsp_bus.status !== want) begin
          status_errors++;
          if (status_errors <= MAX_REPORT)
            $display("status mismatch on response %0d: expected %0d got %0d",
                     checked_cnt, want, rsp_bus.status);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = chs_pkg::OP_INSERT;
    req_bus.item_value = '0;
    for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
    for (int i = 0; i < POOL; i++) begin
      node_val[i]   = '0;
      node_next[i]  = '0;
      free_stack[i] = 8'(i);
    end
    free_nodes = NIL;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_request(row.op, row.value, row.fixed, row.status);
    end

    // hold off until every request has been answered
    req_bus.valid <= 1'b0;
    wait_all_answered();

    refill_value_set();
    repeat (550) send_request(pick_op(40, 30, 25), pick_value(), 1'b0, chs_pkg::STAT_OK);

    // fill the pool, then push past full
    refill_value_set();
    while (free_nodes != 0)
      send_request(pick_op(85, 10, 0), pick_value(), 1'b0, chs_pkg::STAT_OK);
    repeat (20) send_request(pick_op(70, 20, 5), pick_value(), 1'b0, chs_pkg::STAT_OK);

    repeat (400) send_request(pick_op(10, 20, 68), pick_value(), 1'b0, chs_pkg::STAT_OK);

    steady = 1'b1;
    refill_value_set();
    repeat (350) send_request(pick_op(40, 30, 25), pick_value(), 1'b0, chs_pkg::STAT_OK);

    req_bus.valid <= 1'b0;
    wait_all_answered();
    repeat (300) @(posedge clk_i);

    $display("covered %0d inserts, %0d searches, %0d deletes, %0d unused-op requests",
             op_cnt[chs_pkg::OP_INSERT], op_cnt[chs_pkg::OP_SEARCH],
             op_cnt[chs_pkg::OP_DELETE], op_cnt[OP_UNUSED]);
    $display("%0d responses checked, %0d pool-full and %0d not-present answers",
             checked_cnt, full_cnt, absent_cnt);
    if (status_errors == 0) begin
      $display("chained_hash_set verification clean");
    end else begin
      $display("%0d mismatches", status_errors);
      $display("chained_hash_set verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #50000000;
    $display("chained_hash_set verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/chs_pkg.sv
hw/rtl/chs_if.sv
hw/rtl/chs_ctrl.sv
hw/rtl/chs_dp.sv
hw/rtl/chained_hash_set.sv
hw/rtl/chs_checker.sv
test/tb_top.sv
